// ----- hdl/salc_pkg.sv -----
package salc_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int ADDR_W    = 64;
  localparam int TAG_W     = 64;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  localparam logic [1:0] REQ_FETCH  = 2'd0;
  localparam logic [1:0] REQ_LOAD   = 2'd1;
  localparam logic [1:0] REQ_STORE  = 2'd2;
  localparam logic [1:0] REQ_MODIFY = 2'd3;

  localparam logic [1:0] OUT_IGNORED = 2'd0;
  localparam logic [1:0] OUT_HIT     = 2'd1;
  localparam logic [1:0] OUT_FILL    = 2'd2;
  localparam logic [1:0] OUT_EVICT   = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       first_outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_res_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- hdl/salc_ram.sv -----
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/salc_ctrl.sv -----
module salc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output salc_pkg::cmd_t cmd
);
  import salc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/salc_dp.sv -----
module salc_dp #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  salc_pkg::cmd_t                      cmd,
  input  salc_pkg::in_req_t                   in_data,
  output salc_pkg::out_res_t                  out_data
);
  import salc_pkg::*;

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = $bits(line_t);
  localparam int ROW_W  = MAX_WAYS * LINE_W;

  localparam logic [3:0] SBITS_CAP = 4'(MAX_SET_BITS);
  localparam logic [4:0] WAYS_CAP  = 5'(MAX_WAYS);

  logic [2:0] set_bits_r;
  logic [5:0] off_bits_r;
  logic [3:0] ways_r;

  logic [1:0]         req_r;
  logic [TAG_W-1:0]   tag_r;
  logic [SET_W-1:0]   set_r;
  logic [SETS-1:0]    row_vld_r;
  logic [STAMP_W-1:0] time_r;
  logic [CNT_W-1:0]   hit_r, miss_r, evict_r;
  out_res_t           out_r;

  logic [3:0]         sbits;
  logic [6:0]         tag_sh;
  logic [ADDR_W-1:0]  addr_sh;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   set_c;
  logic [TAG_W-1:0]   tag_c;

  logic [4:0]          ways_eff;
  logic [MAX_WAYS-1:0] active;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    wr_row;
  line_t               row_l [MAX_WAYS];
  logic [MAX_WAYS-1:0] hit_vec, emp_vec;
  logic [WAY_W-1:0]    hit_way, emp_way, vic_way, tgt_way;
  logic [STAMP_W-1:0]  best_stamp;
  logic                is_hit, is_emp, is_fetch, is_modify;
  logic [1:0]          outcome;
  logic [STAMP_W-1:0]  time_nxt;
  logic [CNT_W-1:0]    hit_a, hit_nxt, miss_nxt, evict_nxt;
  line_t               new_line;

  // address split for the incoming request
  always_comb begin
    sbits   = ({1'b0, set_bits_r} > SBITS_CAP) ? SBITS_CAP : {1'b0, set_bits_r};
    tag_sh  = {1'b0, off_bits_r} + {3'b000, sbits};
    addr_sh = in_data.address >> off_bits_r;
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (4'(i) < sbits);
    end
    set_c = addr_sh[SET_W-1:0] & set_mask;
    tag_c = (tag_sh >= 7'd64) ? '0 : (in_data.address >> tag_sh);
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && !is_fetch),
    .wr_addr (set_r),
    .wr_data (wr_row),
    .rd_en   (cmd.capture),
    .rd_addr (set_c),
    .rd_data (rd_row)
  );

  // set evaluation
  always_comb begin
    if (ways_r == 4'd0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, ways_r} > WAYS_CAP) begin
      ways_eff = WAYS_CAP;
    end else begin
      ways_eff = {1'b0, ways_r};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w]  = (5'(w) < ways_eff);
      row_l[w]   = row_vld_r[set_r] ? line_t'(rd_row[w*LINE_W +: LINE_W]) : '0;
      hit_vec[w] = active[w] && row_l[w].valid && (row_l[w].tag == tag_r);
      emp_vec[w] = active[w] && !row_l[w].valid;
    end
    hit_way = '0;
    emp_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (emp_vec[w]) begin
        emp_way = WAY_W'(w);
      end
    end
    vic_way    = '0;
    best_stamp = row_l[0].stamp;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (active[w] && (row_l[w].stamp < best_stamp)) begin
        vic_way    = WAY_W'(w);
        best_stamp = row_l[w].stamp;
      end
    end
    is_hit    = |hit_vec;
    is_emp    = |emp_vec;
    is_fetch  = (req_r == REQ_FETCH);
    is_modify = (req_r == REQ_MODIFY);
    tgt_way   = is_hit ? hit_way : (is_emp ? emp_way : vic_way);
    if (is_fetch) begin
      outcome = OUT_IGNORED;
    end else if (is_hit) begin
      outcome = OUT_HIT;
    end else if (is_emp) begin
      outcome = OUT_FILL;
    end else begin
      outcome = OUT_EVICT;
    end
  end

  // counters; the second access of a modify always finds the line just touched
  always_comb begin
    time_nxt  = sat_inc(time_r);
    hit_a     = is_hit ? sat_inc(hit_r) : hit_r;
    hit_nxt   = is_modify ? sat_inc(hit_a) : hit_a;
    miss_nxt  = is_hit ? miss_r : sat_inc(miss_r);
    evict_nxt = (outcome == OUT_EVICT) ? sat_inc(evict_r) : evict_r;
    new_line.valid = 1'b1;
    new_line.tag   = tag_r;
    new_line.stamp = time_nxt;
    for (int w = 0; w < MAX_WAYS; w++) begin
      wr_row[w*LINE_W +: LINE_W] = (WAY_W'(w) == tgt_way) ? new_line : row_l[w];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= '0;
      off_bits_r <= '0;
      ways_r     <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_data[2:0];
        CFG_OFF_BITS: off_bits_r <= cfg_data[5:0];
        CFG_WAYS:     ways_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data.req_type;
      tag_r <= tag_c;
      set_r <= set_c;
    end
    if (cmd.commit) begin
      out_r.first_outcome <= outcome;
      out_r.second_hit    <= is_modify;
      out_r.hit_total     <= is_fetch ? hit_r : hit_nxt;
      out_r.miss_total    <= is_fetch ? miss_r : miss_nxt;
      out_r.eviction_total <= is_fetch ? evict_r : evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      time_r    <= '0;
      hit_r     <= '0;
      miss_r    <= '0;
      evict_r   <= '0;
    end else if (cmd.commit && !is_fetch) begin
      row_vld_r[set_r] <= 1'b1;
      time_r           <= time_nxt;
      hit_r            <= hit_nxt;
      miss_r           <= miss_nxt;
      evict_r          <= evict_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ----- hdl/set_assoc_lru_cache_sim.sv -----
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------
// in_      | in_valid / in_stall | in_data  (req_type, address)
// out_     | out_valid/out_stall | out_data (outcome, second hit, totals)
// cfg_     | cfg_we              | cfg_index, cfg_data
//
// Each request passes through ST_IDLE, where the address is split and the set row
// read, and ST_LOOK, where the way is picked, the row written back and the result
// register loaded; the read of the row memory is registered.
// Reset is synchronous; a per-set valid flag makes every set read as empty,
// so no clearing pass runs after reset.
// A new request is taken while a result waits; a finished request holds in
// ST_LOOK while the result register is full and stalled.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  salc_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output salc_pkg::out_res_t             out_data
);
  import salc_pkg::*;

  cmd_t cmd;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !cmd.capture && in_stall)
    else $error("request captured while another is in flight");

  a_commit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> in_stall && !cmd.capture)
    else $error("commit without a request in flight");

  a_second_hit_modify: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.second_hit |-> out_data.first_outcome != OUT_IGNORED)
    else $error("second hit reported for an ignored request");

endmodule
